### hdl/u16u8_pkg.sv
// shared types and constants of the utf-16 to utf-8 encoder
package u16u8_pkg;

    localparam int UNIT_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int USED_W     = 2;
    localparam int CP_W       = 21;
    localparam int PAY_W      = 10;
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // surrogate tags in the top six bits of a code unit
    localparam logic [5:0] TAG_HIGH = 6'b110110;
    localparam logic [5:0] TAG_LOW  = 6'b110111;

    // offset of the supplementary planes, seen above the low ten bits
    localparam logic [CP_W-PAY_W-1:0] PLANE_BASE = 11'h040;

    // utf-8 lead and continuation prefixes
    localparam logic [BYTE_W-1:0] LEAD2 = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3 = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4 = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT  = 8'h80;

    // byte counts of a character, stored as count minus one
    localparam logic [1:0] LEN1 = 2'd0;
    localparam logic [1:0] LEN2 = 2'd1;
    localparam logic [1:0] LEN3 = 2'd2;
    localparam logic [1:0] LEN4 = 2'd3;

    localparam logic [USED_W-1:0] USED_ERR  = 2'd0;
    localparam logic [USED_W-1:0] USED_BMP  = 2'd1;
    localparam logic [USED_W-1:0] USED_PAIR = 2'd2;

    // one unit of work for the byte sequencer
    typedef struct packed {
        logic                  bad;       // error word goes out first
        logic                  has_char;  // a character follows
        logic [CP_W-1:0]       cp;
        logic [USED_W-1:0]     used;
    } t_cmd;

endpackage

### hdl/u16u8_unit_if.sv
// input channel carrying utf-16 code units
interface u16u8_unit_if;
    logic                          valid;
    logic                          ready;
    logic [u16u8_pkg::UNIT_W-1:0]  code_unit;

    modport source (output valid, output code_unit, input ready);
    modport sink   (input valid, input code_unit, output ready);
endinterface

### hdl/u16u8_byte_if.sv
// output channel carrying utf-8 bytes
interface u16u8_byte_if;
    logic                          valid;
    logic                          ready;
    logic [u16u8_pkg::BYTE_W-1:0]  out_byte;
    logic                          last_byte;
    logic                          bad_pair;
    logic [u16u8_pkg::USED_W-1:0]  units_used;

    modport source (output valid, output out_byte, output last_byte,
                    output bad_pair, output units_used, input ready);
    modport sink   (input valid, input out_byte, input last_byte,
                    input bad_pair, input units_used, output ready);
endinterface

### hdl/u16u8_front.sv
// front end: surrogate pairing and classification into commands
module u16u8_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    u16u8_unit_if.sink           i_unit,
    input  logic                 i_full,
    output logic                 o_push,
    output u16u8_pkg::t_cmd      o_cmd
);
    import u16u8_pkg::*;

    logic              r_pending;
    logic              n_pending;
    logic [PAY_W-1:0]  r_payload;
    logic [PAY_W-1:0]  n_payload;
    logic              is_high;
    logic              is_low;
    logic              accept;
    logic              pair_ok;

    assign is_high = (i_unit.code_unit[UNIT_W-1:PAY_W] == TAG_HIGH);
    assign is_low  = (i_unit.code_unit[UNIT_W-1:PAY_W] == TAG_LOW);
    assign i_unit.ready = !i_full;
    assign accept  = i_unit.valid && i_unit.ready;
    assign pair_ok = r_pending && is_low;

    always_comb begin
        o_cmd.bad      = r_pending && !is_low;
        o_cmd.has_char = pair_ok || !is_high;
        if (pair_ok) begin
            o_cmd.cp   = {{1'b0, r_payload} + PLANE_BASE, i_unit.code_unit[PAY_W-1:0]};
            o_cmd.used = USED_PAIR;
        end else begin
            o_cmd.cp   = {{(CP_W-UNIT_W){1'b0}}, i_unit.code_unit};
            o_cmd.used = USED_BMP;
        end
    end

    assign o_push = accept && (o_cmd.bad || o_cmd.has_char);

    always_comb begin
        n_pending = r_pending;
        n_payload = r_payload;
        if (accept) begin
            n_pending = is_high && !pair_ok;
            n_payload = (is_high && !pair_ok) ? i_unit.code_unit[PAY_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_payload <= '0;
        end else begin
            r_pending <= n_pending;
            r_payload <= n_payload;
        end
    end

    // a lone high surrogate is always held for the next unit
    a_high_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_high && !r_pending) |=> r_pending)
        else $error("high surrogate not held");

endmodule

### hdl/u16u8_fifo.sv
// short command queue between front and back
module u16u8_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  u16u8_pkg::t_cmd      i_cmd,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output u16u8_pkg::t_cmd      o_cmd
);
    import u16u8_pkg::*;

    t_cmd              r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> (!i_push || i_pop) && !(i_push && i_pop && o_empty))
        else $error("queue overflow");

endmodule

### hdl/u16u8_back.sv
// back end: byte sequencer and output register
module u16u8_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  u16u8_pkg::t_cmd      i_cmd,
    output logic                 o_pop,
    u16u8_byte_if.source         o_byte
);
    import u16u8_pkg::*;

    logic               r_busy;
    logic               r_err_done;
    logic [1:0]         r_idx;
    t_cmd               r_cmd;
    logic               r_ov;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_last;
    logic               r_bad;
    logic [USED_W-1:0]  r_used;

    logic [1:0]         len_m1;
    logic               err_phase;
    logic               final_item;
    logic               adv;
    logic [BYTE_W-1:0]  cur_byte;
    logic [1:0]         rem;

    always_comb begin
        if (r_cmd.cp[CP_W-1:16] != '0) begin
            len_m1 = LEN4;
        end else if (r_cmd.cp[15:11] != '0) begin
            len_m1 = LEN3;
        end else if (r_cmd.cp[10:7] != '0) begin
            len_m1 = LEN2;
        end else begin
            len_m1 = LEN1;
        end
    end

    assign err_phase  = r_cmd.bad && !r_err_done;
    assign final_item = err_phase ? !r_cmd.has_char : (r_idx == len_m1);
    assign adv        = r_busy && (!r_ov || o_byte.ready);
    assign o_pop      = !i_empty && (!r_busy || (adv && final_item));
    assign rem        = len_m1 - r_idx;

    always_comb begin
        if (r_idx == 2'd0) begin
            unique case (len_m1)
                LEN1:    cur_byte = {1'b0, r_cmd.cp[6:0]};
                LEN2:    cur_byte = LEAD2 | {3'b0, r_cmd.cp[10:6]};
                LEN3:    cur_byte = LEAD3 | {4'b0, r_cmd.cp[15:12]};
                default: cur_byte = LEAD4 | {5'b0, r_cmd.cp[20:18]};
            endcase
        end else begin
            unique case (rem)
                2'd0:    cur_byte = CONT | {2'b0, r_cmd.cp[5:0]};
                2'd1:    cur_byte = CONT | {2'b0, r_cmd.cp[11:6]};
                default: cur_byte = CONT | {2'b0, r_cmd.cp[17:12]};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (adv) begin
            r_byte <= err_phase ? '0 : cur_byte;
            r_last <= err_phase || (r_idx == len_m1);
            r_bad  <= err_phase;
            r_used <= err_phase ? USED_ERR : r_cmd.used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_err_done <= 1'b0;
            r_idx      <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy     <= 1'b1;
                r_err_done <= 1'b0;
                r_idx      <= '0;
            end else if (adv && final_item) begin
                r_busy <= 1'b0;
            end else if (adv) begin
                if (err_phase) begin
                    r_err_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (adv) begin
                r_ov <= 1'b1;
            end else if (o_byte.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_byte.valid      = r_ov;
    assign o_byte.out_byte   = r_byte;
    assign o_byte.last_byte  = r_last;
    assign o_byte.bad_pair   = r_bad;
    assign o_byte.units_used = r_used;

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && o_byte.bad_pair) |->
            (o_byte.out_byte == '0) && o_byte.last_byte
            && (o_byte.units_used == USED_ERR))
        else $error("malformed error word");

    a_char_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && !o_byte.bad_pair) |->
            (o_byte.units_used == USED_BMP || o_byte.units_used == USED_PAIR))
        else $error("character word without unit count");

    a_cmd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !adv) |=> $stable(r_cmd) && $stable(r_idx))
        else $error("command changed while stalled");

endmodule

### hdl/utf16_to_utf8_encoder.sv
// utf-16 to utf-8 encoder top level: pairing front end, queue, byte sequencer
// throughput: one byte per cycle out when not stalled; a unit yields 1 to 4 bytes, an error
// word counting as one byte, and a held high surrogate yields none
// sync active-low reset clears the held surrogate, the queue, the sequencer and
// the output valid; no byte is presented until a unit is taken after reset
module utf16_to_utf8_encoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    u16u8_unit_if.sink    i_unit,
    u16u8_byte_if.source  o_byte
);
    import u16u8_pkg::*;

    // front to queue
    logic  push;
    t_cmd  push_cmd;
    // queue status and head
    logic  q_full;
    logic  q_empty;
    t_cmd  head_cmd;
    // back takes the head
    logic  pop;

    // front holds a high surrogate and turns each unit into at most one command:
    // an error word flag, a character code point, or both
    u16u8_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_unit  (i_unit),
        .i_full  (q_full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // two-entry queue lets the front keep taking units while the back drains
    u16u8_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    // back walks the bytes of each command into a registered output word;
    // the next command is picked up in the same cycle as the final byte
    u16u8_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_byte  (o_byte)
    );

endmodule

### verif/tb_utf16_to_utf8_encoder.sv
// self-checking testbench of the utf-16 to utf-8 encoder
module tb_utf16_to_utf8_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import u16u8_pkg::*;

    localparam int RANDOM_UNITS   = 430;
    localparam int DRAIN_CYCLES   = 16;    // quiet tail after the last expected word
    localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up

    // one expected utf-8 word on the byte channel
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              char_end;
        logic              broken;
        logic [USED_W-1:0] used;
    } t_utf8_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u16u8_unit_if unit_ch ();
    u16u8_byte_if byte_ch ();

    utf16_to_utf8_encoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_unit  (unit_ch),
        .o_byte  (byte_ch)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // code units still to be sent, and the utf-8 words they must produce
    logic [UNIT_W-1:0] pending_units[$];
    t_utf8_word        expected_words[$];

    // predictor copy of the surrogate holding register
    logic              held_high;
    logic [PAY_W-1:0]  held_bits;

    // run statistics
    int units_in     = 0;
    int words_out    = 0;
    int pairs_seen   = 0;
    int broken_seen  = 0;
    int mismatches   = 0;

    // handshake flags sampled at the rising edge, used by the falling-edge drivers
    logic unit_taken = 1'b0;
    logic word_taken = 1'b0;
    int   idle_cycles = 0;

    // sender burst and gap bookkeeping
    int burst_left = 0;
    int gap_left   = 0;

    // receiver stall pattern, rotated every cycle and replaced now and then
    logic [7:0] stall_mask  = 8'hFF;
    logic [2:0] stall_phase = 3'd0;
    int         mask_age    = 0;

    t_utf8_word got_word;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // queue the utf-8 words of one code point
    task automatic queue_point(input logic [CP_W-1:0] cp, input logic [USED_W-1:0] used);
        if (cp <= 21'h00007F) begin
            expected_words.push_back('{cp[7:0], 1'b1, 1'b0, used});
        end else if (cp <= 21'h0007FF) begin
            expected_words.push_back('{LEAD2 | {3'b000, cp[10:6]}, 1'b0, 1'b0, used});
            expected_words.push_back('{CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0, used});
        end else if (cp <= 21'h00FFFF) begin
            expected_words.push_back('{LEAD3 | {4'b0000, cp[15:12]}, 1'b0, 1'b0, used});
            expected_words.push_back('{CONT | {2'b00, cp[11:6]}, 1'b0, 1'b0, used});
            expected_words.push_back('{CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0, used});
        end else begin
            expected_words.push_back('{LEAD4 | {5'b00000, cp[20:18]}, 1'b0, 1'b0, used});
            expected_words.push_back('{CONT | {2'b00, cp[17:12]}, 1'b0, 1'b0, used});
            expected_words.push_back('{CONT | {2'b00, cp[11:6]}, 1'b0, 1'b0, used});
            expected_words.push_back('{CONT | {2'b00, cp[5:0]}, 1'b1, 1'b0, used});
        end
    endtask

    // advance the pairing state by one accepted code unit
    task automatic encode_unit(input logic [UNIT_W-1:0] cu);
        logic            is_high;
        logic            is_low;
        logic [CP_W-1:0] cp;
        is_high = (cu[15:10] == TAG_HIGH);
        is_low  = (cu[15:10] == TAG_LOW);
        if (held_high && is_low) begin
            // surrogate pair: plane offset plus twenty payload bits
            cp = 21'h010000 + {1'b0, held_bits, cu[9:0]};
            held_high = 1'b0;
            held_bits = '0;
            pairs_seen++;
            queue_point(cp, USED_PAIR);
        end else begin
            if (held_high) begin
                // broken pair: error word, then the unit is taken afresh
                expected_words.push_back('{8'h00, 1'b1, 1'b1, USED_ERR});
                held_high = 1'b0;
                held_bits = '0;
                broken_seen++;
            end
            if (is_high) begin
                held_high = 1'b1;
                held_bits = cu[9:0];
            end else begin
                // plain bmp unit, lone low surrogates included
                queue_point({5'b00000, cu}, USED_BMP);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int pick;
        unit_ch.valid     = 1'b0;
        unit_ch.code_unit = '0;
        byte_ch.ready     = 1'b0;
        i_rst_n           = 1'b0;
        held_high         = 1'b0;
        held_bits         = '0;

        // directed: range edges of each byte length
        pending_units = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                          16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};
        // lowest and highest supplementary pair
        pending_units.push_back(16'hD800); pending_units.push_back(16'hDC00);
        pending_units.push_back(16'hDBFF); pending_units.push_back(16'hDFFF);
        // lone low surrogates with nothing held
        pending_units.push_back(16'hDC00); pending_units.push_back(16'hDFFF);
        // broken pair followed by ascii
        pending_units.push_back(16'hD800); pending_units.push_back(16'h0041);
        // high after high: error only, the second one pairs up
        pending_units.push_back(16'hDBFF); pending_units.push_back(16'hD800);
        pending_units.push_back(16'hDC05);
        // broken pair followed by two- and three-byte units and by zero
        pending_units.push_back(16'hD834); pending_units.push_back(16'h07FF);
        pending_units.push_back(16'hDA00); pending_units.push_back(16'hFFFF);
        pending_units.push_back(16'hD9AA); pending_units.push_back(16'h0000);
        pending_units.push_back(16'hDE01);

        // random: mostly well-formed text, some broken pairs and raw noise
        while (pending_units.size() < RANDOM_UNITS) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                pending_units.push_back(16'($urandom_range(16'h0000, 16'h007F)));
            end else if (pick < 37) begin
                pending_units.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
            end else if (pick < 44) begin
                pending_units.push_back(16'($urandom_range(16'h0800, 16'hD7FF)));
            end else if (pick < 52) begin
                pending_units.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
            end else if (pick < 77) begin
                pending_units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
                pending_units.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end else if (pick < 82) begin
                pending_units.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end else if (pick < 87) begin
                pending_units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
            end else begin
                pending_units.push_back(16'($urandom_range(0, 16'hFFFF)));
            end
        end
        // stream ends on a held high surrogate, which must stay silent
        pending_units.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all units sent, all words back, then a short quiet tail
        while (pending_units.size() != 0 || unit_ch.valid) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d utf-16 units, checked %0d utf-8 words", units_in, words_out);
        $display("%0d surrogate pairs and %0d broken pairs went through", pairs_seen,
                 broken_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // sender: bursts of random length with random gaps, driven on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            unit_ch.valid <= 1'b0;
        end else begin
            // a burst just ran out: pick the gap before the next one
            if (unit_taken && burst_left == 0) begin
                gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                       : $urandom_range(0, 6);
            end
            if (unit_taken || !unit_ch.valid) begin
                if (gap_left == 0 && pending_units.size() != 0) begin
                    // occasional long stretch with no idling at all
                    if (burst_left == 0) begin
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(64, 200)
                                                                 : $urandom_range(1, 16);
                    end
                    unit_ch.code_unit <= pending_units.pop_front();
                    unit_ch.valid     <= 1'b1;
                    burst_left--;
                end else begin
                    unit_ch.valid <= 1'b0;
                    if (gap_left != 0) gap_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: ready follows a rotating stall mask that is redrawn whenever mask_age wraps after counting cycles
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.ready <= 1'b0;
        end else begin
            if (mask_age == 63) begin
                // a quarter of the windows never stall; the others keep at least one open slot
                stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF
                             : (8'($urandom()) | (8'h01 << $urandom_range(0, 7)));
                mask_age = 0;
            end else begin
                mask_age++;
            end
            byte_ch.ready <= stall_mask[stall_phase];
            stall_phase++;
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on accepted units, check accepted words, watch for hangs
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        unit_taken = i_rst_n && unit_ch.valid && unit_ch.ready;
        word_taken = i_rst_n && byte_ch.valid && byte_ch.ready;

        if (unit_taken) begin
            units_in++;
            encode_unit(unit_ch.code_unit);
        end

        if (word_taken) begin
            words_out++;
            if (expected_words.size() == 0) begin
                $error("unexpected word: out_byte 0x%02h last_byte %0b bad_pair %0b",
                       byte_ch.out_byte, byte_ch.last_byte, byte_ch.bad_pair);
                mismatches++;
            end else begin
                got_word = expected_words.pop_front();
                if (byte_ch.out_byte !== got_word.value) begin
                    $error("out_byte: expected 0x%02h, got 0x%02h", got_word.value,
                           byte_ch.out_byte);
                    mismatches++;
                end
                if (byte_ch.last_byte !== got_word.char_end) begin
                    $error("last_byte: expected %0b, got %0b", got_word.char_end,
                           byte_ch.last_byte);
                    mismatches++;
                end
                if (byte_ch.bad_pair !== got_word.broken) begin
                    $error("bad_pair: expected %0b, got %0b", got_word.broken,
                           byte_ch.bad_pair);
                    mismatches++;
                end
                if (byte_ch.units_used !== got_word.used) begin
                    $error("units_used: expected %0d, got %0d", got_word.used,
                           byte_ch.units_used);
                    mismatches++;
                end
            end
        end

        // no handshake on either side for too long means the block is stuck
        if (unit_taken || word_taken) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d quiet cycles, %0d words still expected",
                     idle_cycles, expected_words.size());
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

### sim.f
hdl/u16u8_pkg.sv
hdl/u16u8_unit_if.sv
hdl/u16u8_byte_if.sv
hdl/u16u8_front.sv
hdl/u16u8_fifo.sv
hdl/u16u8_back.sv
hdl/utf16_to_utf8_encoder.sv
verif/tb_utf16_to_utf8_encoder.sv
